[hw/rtl/tint_pkg.sv]
// Shared types, widths and constants for the three-way tonal tint block.
// Holds the pixel and result beat structs, the derived configuration struct
// and the reciprocal table for the smoothstep edge span. No dependencies.
package tint_pkg;

  localparam int PIXEL_WIDTH = 16;
  localparam int OUT_W       = PIXEL_WIDTH - 1;
  localparam int TINT_W      = 16;
  localparam int TINT_REG_W  = 3 * TINT_W;

  localparam int APB_AW = 6;
  localparam int APB_DW = 64;
  localparam int REG_W  = 3;

  localparam logic [REG_W-1:0] REG_SHADOW    = 3'd0;
  localparam logic [REG_W-1:0] REG_MIDTONE   = 3'd1;
  localparam logic [REG_W-1:0] REG_HIGHLIGHT = 3'd2;
  localparam logic [REG_W-1:0] REG_GLOBAL    = 3'd3;
  localparam logic [REG_W-1:0] REG_BALANCE   = 3'd4;
  localparam logic [REG_W-1:0] REG_SOFTNESS  = 3'd5;

  localparam int BAL_W    = 8;
  localparam int SOFT_W   = 7;
  localparam int BAL_MAX  = 100;
  localparam int SOFT_MAX = 100;
  localparam int SOFT_BASE = 20;

  // Q16 fixed point: 1.0 = 65536.
  localparam int FRAC_W   = 16;
  localparam int Q16_ONE  = 65536;
  localparam int PIVOT_LO = 19661;
  localparam int PIVOT_HI = 45875;

  // Rec.709 luma in Q0.16.
  localparam int LUMA_W = 17;
  localparam logic signed [LUMA_W-1:0] LUMA_R = 17'sd13933;
  localparam logic signed [LUMA_W-1:0] LUMA_G = 17'sd46872;
  localparam logic signed [LUMA_W-1:0] LUMA_B = 17'sd4731;
  localparam int LUMA_SHIFT = 12;

  // Constant division by multiplication with a rounded-up reciprocal.
  localparam int SHNUM_W  = 24;
  localparam int DIV1K_W  = 25;
  localparam int DIV1K_SH = 34;
  localparam logic [DIV1K_W-1:0] DIV1K_M = 25'd17179870;
  localparam int SHIFT_MUL_LSB = 15;
  localparam int SHIFT_ROUND   = 500;

  localparam int HWNUM_W  = 21;
  localparam int DIV100_W = 24;
  localparam int DIV100_SH = 30;
  localparam logic [DIV100_W-1:0] DIV100_M = 24'd10737419;
  localparam int HW_MUL_LSB = 14;
  localparam int HW_ROUND   = 50;

  localparam int SHIFT_W = 15;
  localparam int HALFW_W = 15;
  localparam int EDGE_W  = 17;
  localparam int RECIP_W = 20;

  // Datapath widths.
  localparam int LPROD_W = PIXEL_WIDTH + LUMA_W;
  localparam int LSUM_W  = LPROD_W + 2;
  localparam int Y_W     = PIXEL_WIDTH + 4;
  localparam int DIFF_W  = Y_W + 1;
  localparam int D_W     = Y_W;
  localparam int M_W     = D_W + RECIP_W;
  localparam int T_W     = FRAC_W + 1;
  localparam int TT_W    = 2 * FRAC_W + 1;
  localparam int K_W     = FRAC_W + 2;
  localparam int P_W     = 3 * FRAC_W + 1;
  localparam int WPROD_W = T_W + 1 + TINT_W;
  localparam int ACC_W   = PIXEL_WIDTH + 19;
  localparam int RQ_W    = ACC_W - 1 - FRAC_W;

  typedef struct packed {
    logic signed [PIXEL_WIDTH-1:0] red_in;
    logic signed [PIXEL_WIDTH-1:0] green_in;
    logic signed [PIXEL_WIDTH-1:0] blue_in;
    logic [PIXEL_WIDTH-1:0]        alpha_in;
  } tint_in_t;

  typedef struct packed {
    logic [OUT_W-1:0]       red_out;
    logic [OUT_W-1:0]       green_out;
    logic [OUT_W-1:0]       blue_out;
    logic [PIXEL_WIDTH-1:0] alpha_out;
  } tint_out_t;

  typedef struct packed {
    logic [TINT_REG_W-1:0]    shadow_tint;
    logic [TINT_REG_W-1:0]    midtone_tint;
    logic [TINT_REG_W-1:0]    highlight_tint;
    logic [TINT_REG_W-1:0]    global_tint;
    logic signed [EDGE_W-1:0] lo_start;
    logic signed [EDGE_W-1:0] hi_start;
    logic [RECIP_W-1:0]       recip;
  } tint_cfg_t;

  // round(200 * 65536 / (20 + softness)) for softness 0 to 100.
  localparam logic [RECIP_W-1:0] RECIP_TABLE [0:SOFT_MAX] = '{
    20'd655360, 20'd624152, 20'd595782, 20'd569878, 20'd546133,
    20'd524288, 20'd504123, 20'd485452, 20'd468114, 20'd451972,
    20'd436907, 20'd422813, 20'd409600, 20'd397188, 20'd385506,
    20'd374491, 20'd364089, 20'd354249, 20'd344926, 20'd336082,
    20'd327680, 20'd319688, 20'd312076, 20'd304819, 20'd297891,
    20'd291271, 20'd284939, 20'd278877, 20'd273067, 20'd267494,
    20'd262144, 20'd257004, 20'd252062, 20'd247306, 20'd242726,
    20'd238313, 20'd234057, 20'd229951, 20'd225986, 20'd222156,
    20'd218453, 20'd214872, 20'd211406, 20'd208051, 20'd204800,
    20'd201649, 20'd198594, 20'd195630, 20'd192753, 20'd189959,
    20'd187246, 20'd184608, 20'd182044, 20'd179551, 20'd177124,
    20'd174763, 20'd172463, 20'd170223, 20'd168041, 20'd165914,
    20'd163840, 20'd161817, 20'd159844, 20'd157918, 20'd156038,
    20'd154202, 20'd152409, 20'd150657, 20'd148945, 20'd147272,
    20'd145636, 20'd144035, 20'd142470, 20'd140938, 20'd139438,
    20'd137971, 20'd136533, 20'd135126, 20'd133747, 20'd132396,
    20'd131072, 20'd129774, 20'd128502, 20'd127254, 20'd126031,
    20'd124830, 20'd123653, 20'd122497, 20'd121363, 20'd120250,
    20'd119156, 20'd118083, 20'd117029, 20'd115993, 20'd114975,
    20'd113976, 20'd112993, 20'd112027, 20'd111078, 20'd110145,
    20'd109227
  };

endpackage

[hw/rtl/tint_regs.sv]
// Configuration registers behind the APB-style port, plus the two register
// stages that turn balance and softness into edge starts and the reciprocal.
// Depends on tint_pkg.
module tint_regs import tint_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output tint_cfg_t         cfg
);

  logic [TINT_REG_W-1:0] shadow_tint;
  logic [TINT_REG_W-1:0] midtone_tint;
  logic [TINT_REG_W-1:0] highlight_tint;
  logic [TINT_REG_W-1:0] global_tint;
  logic [BAL_W-1:0]      pivot_balance;
  logic [SOFT_W-1:0]     edge_softness;

  logic              wr_en;
  logic [REG_W-1:0]  reg_idx;

  logic signed [BAL_W-1:0]  bal_s;
  logic                     bal_neg;
  logic [SOFT_W-1:0]        bal_mag;
  logic [SOFT_W+1:0]        bal_x3;
  logic [SHNUM_W-1:0]       shift_num;
  logic [SHNUM_W+DIV1K_W-1:0] shift_prod;
  logic [SHIFT_W-1:0]       shift_mag;
  logic [SOFT_W-1:0]        soft_c;
  logic [SOFT_W-1:0]        soft_span;
  logic [HWNUM_W-1:0]       hw_num;
  logic [HWNUM_W+DIV100_W-1:0] hw_prod;

  logic signed [SHIFT_W-1:0] shift_q;
  logic [HALFW_W-1:0]        halfw_q;
  logic [RECIP_W-1:0]        recip_q;
  logic signed [EDGE_W-1:0]  lo_start;
  logic signed [EDGE_W-1:0]  hi_start;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_tint    <= '0;
      midtone_tint   <= '0;
      highlight_tint <= '0;
      global_tint    <= '0;
      pivot_balance  <= '0;
      edge_softness  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHADOW:    shadow_tint    <= pwdata[TINT_REG_W-1:0];
        REG_MIDTONE:   midtone_tint   <= pwdata[TINT_REG_W-1:0];
        REG_HIGHLIGHT: highlight_tint <= pwdata[TINT_REG_W-1:0];
        REG_GLOBAL:    global_tint    <= pwdata[TINT_REG_W-1:0];
        REG_BALANCE:   pivot_balance  <= pwdata[BAL_W-1:0];
        REG_SOFTNESS:  edge_softness  <= pwdata[SOFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHADOW:    prdata = APB_DW'(shadow_tint);
      REG_MIDTONE:   prdata = APB_DW'(midtone_tint);
      REG_HIGHLIGHT: prdata = APB_DW'(highlight_tint);
      REG_GLOBAL:    prdata = APB_DW'(global_tint);
      REG_BALANCE:   prdata = APB_DW'(pivot_balance);
      REG_SOFTNESS:  prdata = APB_DW'(edge_softness);
      default:       prdata = '0;
    endcase
  end

  // Balance is clamped to +-100 and scaled by 98.304 with rounding away from
  // zero; the half-width is round((20 + softness) * 163.84).
  always_comb begin
    bal_s = $signed(pivot_balance);
    if (bal_s > $signed(BAL_W'(BAL_MAX))) begin
      bal_s = $signed(BAL_W'(BAL_MAX));
    end else if (bal_s < -$signed(BAL_W'(BAL_MAX))) begin
      bal_s = -$signed(BAL_W'(BAL_MAX));
    end
    bal_neg    = bal_s[BAL_W-1];
    bal_mag    = bal_neg ? SOFT_W'(-bal_s) : SOFT_W'(bal_s);
    bal_x3     = (SOFT_W+2)'({bal_mag, 1'b0}) + (SOFT_W+2)'(bal_mag);
    shift_num  = SHNUM_W'({bal_x3, SHIFT_MUL_LSB'(0)}) + SHNUM_W'(SHIFT_ROUND);
    shift_prod = shift_num * DIV1K_M;
    shift_mag  = shift_prod[DIV1K_SH+SHIFT_W-1:DIV1K_SH];

    soft_c    = (edge_softness > SOFT_W'(SOFT_MAX)) ? SOFT_W'(SOFT_MAX) : edge_softness;
    soft_span = soft_c + SOFT_W'(SOFT_BASE);
    hw_num    = HWNUM_W'({soft_span, HW_MUL_LSB'(0)}) + HWNUM_W'(HW_ROUND);
    hw_prod   = hw_num * DIV100_M;
  end

  always_ff @(posedge clk) begin
    shift_q  <= bal_neg ? -$signed(shift_mag) : $signed(shift_mag);
    halfw_q  <= hw_prod[DIV100_SH+HALFW_W-1:DIV100_SH];
    recip_q  <= RECIP_TABLE[soft_c];
    lo_start <= EDGE_W'(PIVOT_LO) + EDGE_W'(shift_q) - EDGE_W'(halfw_q);
    hi_start <= EDGE_W'(PIVOT_HI) + EDGE_W'(shift_q) - EDGE_W'(halfw_q);
  end

  always_comb begin
    cfg.shadow_tint    = shadow_tint;
    cfg.midtone_tint   = midtone_tint;
    cfg.highlight_tint = highlight_tint;
    cfg.global_tint    = global_tint;
    cfg.lo_start       = lo_start;
    cfg.hi_start       = hi_start;
    cfg.recip          = recip_q;
  end

endmodule

[hw/rtl/tint_pipe.sv]
// Nine-stage pixel pipeline: luma, smoothstep region weights, tint mix,
// clamp and round. Each stage holds its own valid bit and stalls locally.
// Depends on tint_pkg.
module tint_pipe import tint_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tint_cfg_t cfg,
  input  logic      pixel_valid,
  output logic      pixel_ready,
  input  tint_in_t  pixel,
  output logic      graded_valid,
  input  logic      graded_ready,
  output tint_out_t graded
);

  localparam int NSTAGE = 9;

  logic [NSTAGE:1]   v;
  logic [NSTAGE+1:1] rdy;

  tint_in_t s1_pix, s2_pix, s3_pix, s4_pix, s5_pix, s6_pix, s7_pix, s8_pix;

  logic signed [LPROD_W-1:0] s1_lr, s1_lg, s1_lb;
  logic signed [LSUM_W-1:0]  lsum;
  logic signed [Y_W-1:0]     s2_y;
  logic signed [DIFF_W-1:0]  diff_lo, diff_hi;
  logic [D_W-1:0]            s3_d_lo, s3_d_hi;
  logic [M_W-1:0]            s4_m_lo, s4_m_hi;
  logic [T_W-1:0]            t_lo, t_hi;
  logic [2*T_W-1:0]          tt_lo, tt_hi;
  logic [TT_W-1:0]           s5_tt_lo, s5_tt_hi;
  logic [K_W-1:0]            s5_k_lo, s5_k_hi;
  logic [TT_W+K_W-1:0]       p_lo, p_hi;
  logic [P_W-1:0]            s6_p_lo, s6_p_hi;
  logic [P_W-1:0]            pr_lo, pr_hi;
  logic [T_W-1:0]            s_lo, s_hi;
  logic [T_W-1:0]            s7_ws, s7_wm, s7_wh;
  logic signed [TINT_W-1:0]  tint_s [3];
  logic signed [TINT_W-1:0]  tint_m [3];
  logic signed [TINT_W-1:0]  tint_h [3];
  logic signed [TINT_W-1:0]  tint_g [3];
  logic signed [WPROD_W-1:0] s8_ps [3];
  logic signed [WPROD_W-1:0] s8_pm [3];
  logic signed [WPROD_W-1:0] s8_ph [3];
  logic signed [PIXEL_WIDTH-1:0] s8_ch [3];
  logic signed [ACC_W-1:0]   acc [3];
  logic [ACC_W-1:0]          rnd [3];
  logic [OUT_W-1:0]          res [3];
  tint_out_t                 graded_next;
  logic                      in_acc, out_acc;

  assign pixel_ready  = rdy[1];
  assign graded_valid = v[NSTAGE];
  assign in_acc       = pixel_valid && pixel_ready;
  assign out_acc      = graded_valid && graded_ready;

  always_comb begin
    rdy[NSTAGE+1] = graded_ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= pixel_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_comb begin
    lsum    = LSUM_W'(s1_lr) + LSUM_W'(s1_lg) + LSUM_W'(s1_lb);
    diff_lo = DIFF_W'(s2_y) - DIFF_W'(cfg.lo_start);
    diff_hi = DIFF_W'(s2_y) - DIFF_W'(cfg.hi_start);

    if (s4_m_lo[M_W-1:FRAC_W] > (M_W-FRAC_W)'(Q16_ONE)) begin
      t_lo = T_W'(Q16_ONE);
    end else begin
      t_lo = s4_m_lo[FRAC_W+T_W-1:FRAC_W];
    end
    if (s4_m_hi[M_W-1:FRAC_W] > (M_W-FRAC_W)'(Q16_ONE)) begin
      t_hi = T_W'(Q16_ONE);
    end else begin
      t_hi = s4_m_hi[FRAC_W+T_W-1:FRAC_W];
    end
    tt_lo = t_lo * t_lo;
    tt_hi = t_hi * t_hi;

    p_lo  = s5_tt_lo * s5_k_lo;
    p_hi  = s5_tt_hi * s5_k_hi;

    pr_lo = s6_p_lo + (P_W'(1) << (2*FRAC_W-1));
    pr_hi = s6_p_hi + (P_W'(1) << (2*FRAC_W-1));
    s_lo  = pr_lo[P_W-1:2*FRAC_W];
    s_hi  = pr_hi[P_W-1:2*FRAC_W];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tint_s[c] = $signed(cfg.shadow_tint[c*TINT_W +: TINT_W]);
      tint_m[c] = $signed(cfg.midtone_tint[c*TINT_W +: TINT_W]);
      tint_h[c] = $signed(cfg.highlight_tint[c*TINT_W +: TINT_W]);
      tint_g[c] = $signed(cfg.global_tint[c*TINT_W +: TINT_W]);
    end
    s8_ch[0] = s8_pix.red_in;
    s8_ch[1] = s8_pix.green_in;
    s8_ch[2] = s8_pix.blue_in;
    for (int c = 0; c < 3; c++) begin
      acc[c] = (ACC_W'(s8_ch[c]) <<< FRAC_W) + ACC_W'(s8_ps[c]) + ACC_W'(s8_pm[c])
             + ACC_W'(s8_ph[c]) + (ACC_W'(tint_g[c]) <<< FRAC_W);
      rnd[c] = acc[c] + (ACC_W'(1) << (FRAC_W-1));
      if (acc[c] <= 0) begin
        res[c] = '0;
      end else if (rnd[c][ACC_W-2:FRAC_W] > RQ_W'(2**OUT_W - 1)) begin
        res[c] = OUT_W'(2**OUT_W - 1);
      end else begin
        res[c] = rnd[c][FRAC_W+OUT_W-1:FRAC_W];
      end
    end
    graded_next.red_out   = res[0];
    graded_next.green_out = res[1];
    graded_next.blue_out  = res[2];
    graded_next.alpha_out = s8_pix.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_pix <= pixel;
      s1_lr  <= pixel.red_in * LUMA_R;
      s1_lg  <= pixel.green_in * LUMA_G;
      s1_lb  <= pixel.blue_in * LUMA_B;
    end
    if (rdy[2]) begin
      s2_pix <= s1_pix;
      s2_y   <= lsum[LUMA_SHIFT+Y_W-1:LUMA_SHIFT];
    end
    if (rdy[3]) begin
      s3_pix  <= s2_pix;
      s3_d_lo <= (diff_lo > 0) ? diff_lo[D_W-1:0] : '0;
      s3_d_hi <= (diff_hi > 0) ? diff_hi[D_W-1:0] : '0;
    end
    if (rdy[4]) begin
      s4_pix  <= s3_pix;
      s4_m_lo <= s3_d_lo * cfg.recip;
      s4_m_hi <= s3_d_hi * cfg.recip;
    end
    if (rdy[5]) begin
      s5_pix   <= s4_pix;
      s5_tt_lo <= tt_lo[TT_W-1:0];
      s5_tt_hi <= tt_hi[TT_W-1:0];
      s5_k_lo  <= K_W'(3*Q16_ONE) - K_W'({t_lo, 1'b0});
      s5_k_hi  <= K_W'(3*Q16_ONE) - K_W'({t_hi, 1'b0});
    end
    if (rdy[6]) begin
      s6_pix  <= s5_pix;
      s6_p_lo <= p_lo[P_W-1:0];
      s6_p_hi <= p_hi[P_W-1:0];
    end
    if (rdy[7]) begin
      s7_pix <= s6_pix;
      s7_ws  <= T_W'(Q16_ONE) - s_lo;
      s7_wh  <= s_hi;
      s7_wm  <= (s_lo > s_hi) ? (s_lo - s_hi) : '0;
    end
    if (rdy[8]) begin
      s8_pix <= s7_pix;
      for (int c = 0; c < 3; c++) begin
        s8_ps[c] <= $signed({1'b0, s7_ws}) * tint_s[c];
        s8_pm[c] <= $signed({1'b0, s7_wm}) * tint_m[c];
        s8_ph[c] <= $signed({1'b0, s7_wh}) * tint_h[c];
      end
    end
    if (rdy[9]) begin
      graded <= graded_next;
    end
  end

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !rst |=> $countones(v) == $past($countones(v)) + int'($past(in_acc))
                              - int'($past(out_acc)))
    else $error("pipeline occupancy does not match accepted and delivered beats");

  a_weights: assert property (@(posedge clk) disable iff (rst)
    v[7] |-> (s7_ws <= T_W'(Q16_ONE)) && (s7_wm <= T_W'(Q16_ONE))
             && (s7_wh <= T_W'(Q16_ONE)))
    else $error("region weight above one");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> pixel_ready)
    else $error("input stalled while the first stage is empty");

endmodule

[hw/rtl/three_way_tonal_tint_unit.sv]
// Three-way tonal tint unit: top level joining the register file and the
// pixel pipeline. Depends on tint_pkg, tint_regs and tint_pipe.
//
// The unit takes one RGBA pixel beat per clock while pixel_ready is high
// and returns one graded beat per pixel, in order, after the pixel passes
// all nine stages. Throughput is one beat per cycle while not stalled;
// every stage holds its own valid bit, so a stalled output only holds back
// stages that are full and empty stages keep taking pixels. Tints, balance
// and softness are written through the APB-style port at byte address 8
// times the register number (shadow, midtone, highlight, global, balance,
// softness) and must be written while no pixel is in flight; the derived
// edge positions settle in time for a pixel taken on the cycle after the
// write.
module three_way_tonal_tint_unit import tint_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  tint_in_t          pixel,
  output logic              graded_valid,
  input  logic              graded_ready,
  output tint_out_t         graded
);

  tint_cfg_t cfg;

  tint_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tint_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .graded_valid (graded_valid),
    .graded_ready (graded_ready),
    .graded       (graded)
  );

endmodule
